>>> rtl/mspdf_pkg.sv
package mspdf_pkg;

  localparam int MAX_DATA_BYTES = 32;

  // byte position runs 0 .. MAX_DATA_BYTES+4
  localparam int POS_W = $clog2(MAX_DATA_BYTES + 5);
  localparam int LEN_W = 6;
  localparam int CMP_W = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [7:0] SYM_START  = 8'h24;
  localparam logic [7:0] SYM_LETTER = 8'h4D;
  localparam logic [7:0] SYM_DIR    = 8'h3E;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(7);
  localparam logic [7:0]       CMD_RESET = 8'h6C;

  localparam logic [CFG_IDX_W-1:0] CFG_EXP_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_CMD = 1'b1;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_START  = 3'd1,
    ST_LETTER = 3'd2,
    ST_DIR    = 3'd3,
    ST_SIZE   = 3'd4,
    ST_CSUM   = 3'd5,
    ST_CMD    = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic       frame_end;
    status_t    status;
  } result_t;

endpackage

>>> rtl/mspdf_parser.sv
module mspdf_parser (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [mspdf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mspdf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                               accept,
  input  logic [7:0]                         rx_byte,
  output mspdf_pkg::result_t                 res
);

  localparam int POS_W = mspdf_pkg::POS_W;
  localparam int CMP_W = mspdf_pkg::CMP_W;

  logic [mspdf_pkg::LEN_W-1:0] exp_len_r;
  logic [7:0]                  exp_cmd_r;

  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [7:0]          xor_r, xor_nxt;
  mspdf_pkg::status_t  err_r, err_nxt;
  logic [7:0]          cmd_r, cmd_nxt;

  logic [CMP_W-1:0] len_ext;
  logic [POS_W-1:0] eff_len;
  logic [POS_W-1:0] last_pos;
  logic [7:0]       size_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_len_r <= mspdf_pkg::LEN_RESET;
      exp_cmd_r <= mspdf_pkg::CMD_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mspdf_pkg::CFG_EXP_LEN: exp_len_r <= cfg_data[mspdf_pkg::LEN_W-1:0];
        mspdf_pkg::CFG_EXP_CMD: exp_cmd_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // clamp length to 1 .. MAX_DATA_BYTES
  always_comb begin
    len_ext = CMP_W'(exp_len_r);
    priority if (len_ext == '0) begin
      eff_len = POS_W'(1);
    end else if (len_ext > CMP_W'(mspdf_pkg::MAX_DATA_BYTES)) begin
      eff_len = POS_W'(mspdf_pkg::MAX_DATA_BYTES);
    end else begin
      eff_len = len_ext[POS_W-1:0];
    end
    last_pos = eff_len + POS_W'(4);
    size_val = 8'(eff_len - POS_W'(1));
  end

  always_comb begin
    pos_nxt = pos_r;
    xor_nxt = xor_r;
    err_nxt = err_r;
    cmd_nxt = cmd_r;
    res     = '0;
    res.status = mspdf_pkg::ST_OK;
    if (pos_r >= last_pos) begin
      res.frame_end = 1'b1;
      priority if (err_r != mspdf_pkg::ST_OK) begin
        res.status = err_r;
      end else if (xor_r != rx_byte) begin
        res.status = mspdf_pkg::ST_CSUM;
      end else if (cmd_r != exp_cmd_r) begin
        res.status = mspdf_pkg::ST_CMD;
      end else begin
        res.status = mspdf_pkg::ST_OK;
      end
      pos_nxt = '0;
      xor_nxt = '0;
      err_nxt = mspdf_pkg::ST_OK;
      cmd_nxt = '0;
    end else begin
      pos_nxt = pos_r + POS_W'(1);
      unique case (pos_r)
        POS_W'(0): begin
          if (err_r == mspdf_pkg::ST_OK && rx_byte != mspdf_pkg::SYM_START)
            err_nxt = mspdf_pkg::ST_START;
        end
        POS_W'(1): begin
          if (err_r == mspdf_pkg::ST_OK && rx_byte != mspdf_pkg::SYM_LETTER)
            err_nxt = mspdf_pkg::ST_LETTER;
        end
        POS_W'(2): begin
          if (err_r == mspdf_pkg::ST_OK && rx_byte != mspdf_pkg::SYM_DIR)
            err_nxt = mspdf_pkg::ST_DIR;
        end
        POS_W'(3): begin
          if (err_r == mspdf_pkg::ST_OK && rx_byte != size_val)
            err_nxt = mspdf_pkg::ST_SIZE;
          xor_nxt = size_val;
        end
        default: begin
          if (pos_r == POS_W'(4)) cmd_nxt = rx_byte;
          xor_nxt        = xor_r ^ rx_byte;
          res.data_byte  = rx_byte;
          res.data_valid = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      xor_r <= '0;
      err_r <= mspdf_pkg::ST_OK;
      cmd_r <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
      xor_r <= xor_nxt;
      err_r <= err_nxt;
      cmd_r <= cmd_nxt;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(mspdf_pkg::MAX_DATA_BYTES + 4))
    else $error("byte position past end of longest frame");

  a_end_not_data: assert property (@(posedge clk) disable iff (!rst_n)
    res.frame_end |-> !res.data_valid)
    else $error("checksum byte flagged as data");

  a_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && res.frame_end) |=> (pos_r == '0 && err_r == mspdf_pkg::ST_OK))
    else $error("frame state not cleared after checksum byte");

endmodule

>>> rtl/mspdf_skid.sv
module mspdf_skid (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mspdf_pkg::result_t push_res,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output mspdf_pkg::result_t out_res
);

  logic               main_valid_r, main_valid_nxt;
  logic               skid_valid_r, skid_valid_nxt;
  mspdf_pkg::result_t main_r, main_nxt;
  mspdf_pkg::result_t skid_r, skid_nxt;
  logic               pop;

  assign pop       = main_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_res   = main_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_nxt       = push_res;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_res;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry held with empty output register");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(main_valid_r && out_stall))
    else $error("skid filled while output register was free");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !pop) |=> (skid_valid_r && $stable(skid_r)))
    else $error("skid entry lost or overwritten");

endmodule

>>> rtl/msp_response_deframer.sv
// Each input transfer's result is registered in the output register, or in the skid entry while the output stalls.
// Throughput: one byte per cycle while in_stall is low; frame tracking is a position compare and an XOR.
// A two-entry output buffer lets the input take one more byte during an output stall before in_stall rises.
// Reset (rst_n, synchronous, active low) clears frame state and buffer,
// and loads expected_len = 7, expected_cmd = 0x6c.
module msp_response_deframer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [mspdf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mspdf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_rx_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_data_byte,
  output logic                             out_data_valid,
  output logic                             out_frame_end,
  output logic [2:0]                       out_status
);

  logic               accept;
  logic               full;
  mspdf_pkg::result_t res;
  mspdf_pkg::result_t out_res;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  mspdf_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .rx_byte   (in_rx_byte),
    .res       (res)
  );

  mspdf_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_res  (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_data_byte  = out_res.data_byte;
  assign out_data_valid = out_res.data_valid;
  assign out_frame_end  = out_res.frame_end;
  assign out_status     = 3'(out_res.status);

endmodule
